/* rtl/core/rmla_pkg.sv */
`timescale 1ns / 1ps
package rmla_pkg;
    localparam int CHANNELS_DEF = 16;
    localparam int CH_W         = 4;
    localparam int LIMIT_SCALE  = 100;
    localparam int IN_W         = 152;
    localparam int OUT_W        = 48;
    localparam int DIV_STEPS    = 28;
    // truncating unsigned 32-bit divide by LIMIT_SCALE: (x * RECIP_100) >> RECIP_SHIFT
    localparam logic [31:0] RECIP_100 = 32'h51EB851F;
    localparam int RECIP_SHIFT  = 37;
    localparam logic OP_SAMPLE  = 1'b0;
    localparam logic OP_LOAD    = 1'b1;
    localparam logic [1:0] ST_NORMAL  = 2'd0;
    localparam logic [1:0] ST_UNDER   = 2'd1;
    localparam logic [1:0] ST_OVER    = 2'd2;
    localparam logic [1:0] ST_IGNORED = 2'd3;
    localparam logic [1:0] SUP_ON    = 2'd0;
    localparam logic [1:0] SUP_OFF   = 2'd1;
    localparam logic [1:0] SUP_FAULT = 2'd2;

    typedef struct packed {
        logic start_mul;
        logic step_div;
        logic saturate;
        logic quotient;
        logic finish;
        logic load;
        logic blank;
    } t_cmd;

    typedef struct packed {
        logic in_range;
        logic div_last;
    } t_sts;
endpackage

/* rtl/core/rail_monitor_limit_alert.sv */
`timescale 1ns / 1ps
// a sample runs S_MUL, S_DIV, S_SAT, S_QUO, S_FIN, S_WAIT; a load goes to S_WAIT
// throughput: one item at a time; the 28-step restoring divider sets the sample rate
// a new item is taken once the previous result has been accepted downstream
// reset: synchronous active-low i_rst_n; tables go to reset values, flags clear
module rail_monitor_limit_alert #(
    parameter int CHANNELS = rmla_pkg::CHANNELS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // op, channel, raw_sample, supply_up, scale_mul, scale_div,
    // scale_offset, limit_low, limit_high, switched_domain
    input  logic [rmla_pkg::IN_W-1:0]   s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // out_channel, scaled_reading, status, report, supply_state
    output logic [rmla_pkg::OUT_W-1:0]  m_axis_tdata
);
    import rmla_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic busy, start, r_valid;

    assign s_axis_tready = !busy;
    assign start = s_axis_tvalid && s_axis_tready;

    // result valid once the controller drops into its wait state
    logic done;
    assign done = busy && !r_valid && !cmd.step_div && !cmd.start_mul && !cmd.saturate
                  && !cmd.quotient && !cmd.finish;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (r_valid && m_axis_tready) begin
            r_valid <= 1'b0;
        end else if (done) begin
            r_valid <= 1'b1;
        end
    end
    assign m_axis_tvalid = r_valid;

    rmla_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
        .i_op(s_axis_tdata[0]), .i_sts(sts),
        .i_out_free(r_valid && m_axis_tready),
        .o_cmd(cmd), .o_busy(busy)
    );

    rmla_dp #(.CHANNELS(CHANNELS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
        .i_item(s_axis_tdata), .i_cmd(cmd), .o_sts(sts), .o_result(m_axis_tdata)
    );
endmodule

/* rtl/core/rmla_ctrl.sv */
`timescale 1ns / 1ps
module rmla_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_op,
    input  rmla_pkg::t_sts  i_sts,
    input  logic            i_out_free,
    output rmla_pkg::t_cmd  o_cmd,
    output logic            o_busy
);
    import rmla_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_MUL, S_DIV, S_SAT, S_QUO, S_FIN, S_WAIT} t_state;
    t_state r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_start) begin
                    r_state <= (i_sts.in_range && i_op == OP_SAMPLE) ? S_MUL : S_WAIT;
                end
                S_MUL:  r_state <= S_DIV;
                S_DIV:  if (i_sts.div_last) r_state <= S_SAT;
                S_SAT:  r_state <= S_QUO;
                S_QUO:  r_state <= S_FIN;
                S_FIN:  r_state <= S_WAIT;
                S_WAIT: if (i_out_free) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.start_mul = (r_state == S_MUL);
        o_cmd.step_div  = (r_state == S_DIV);
        o_cmd.saturate  = (r_state == S_SAT);
        o_cmd.quotient  = (r_state == S_QUO);
        o_cmd.finish    = (r_state == S_FIN);
        o_cmd.load      = (r_state == S_IDLE) && i_start && i_sts.in_range
                          && i_op == OP_LOAD;
        o_cmd.blank     = (r_state == S_IDLE) && i_start;
    end
    assign o_busy = (r_state != S_IDLE);
endmodule

/* rtl/core/rmla_dp.sv */
`timescale 1ns / 1ps
module rmla_dp #(
    parameter int CHANNELS = rmla_pkg::CHANNELS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [rmla_pkg::IN_W-1:0]   i_item,
    input  rmla_pkg::t_cmd              i_cmd,
    output rmla_pkg::t_sts              o_sts,
    output logic [rmla_pkg::OUT_W-1:0]  o_result
);
    import rmla_pkg::*;

    localparam int CI_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic signed [15:0] r_mul [CHANNELS];
    logic [14:0]        r_div [CHANNELS];
    logic signed [31:0] r_off [CHANNELS];
    logic signed [31:0] r_lo  [CHANNELS];
    logic signed [31:0] r_hi  [CHANNELS];
    logic [CHANNELS-1:0] r_dom;
    logic [4:0]         r_flg [CHANNELS];

    logic [CH_W-1:0]  r_ch;
    logic [11:0]      r_raw;
    logic             r_up;
    logic             r_neg;
    logic [27:0]      r_num;   // |product| then quotient
    logic [14:0]      r_rem;
    logic [14:0]      r_dv;
    logic [4:0]       r_cnt;
    logic signed [31:0] r_reading;
    logic signed [31:0] r_q;
    logic [1:0]       r_status;
    logic             r_report;

    logic in_rng;
    logic [CH_W-1:0] ich;
    logic [CI_W-1:0] li;
    assign ich    = i_item[4:1];
    assign li     = CI_W'(ich);
    assign in_rng = {28'd0, ich} < CHANNELS;
    assign o_sts.in_range = in_rng;
    assign o_sts.div_last = (r_cnt == 5'(DIV_STEPS - 1));

    logic [CI_W-1:0] ci;
    assign ci = CI_W'(r_ch);

    // sign-magnitude multiply, restoring divide
    logic signed [28:0] prod;
    logic [27:0] pmag;
    logic [15:0] trial;
    assign prod = $signed({1'b0, r_raw}) * r_mul[ci];
    assign pmag = prod[28] ? 28'(-prod) : 28'(prod);
    assign trial = {r_rem, r_num[27]} - {1'b0, r_dv};

    // offset and saturate
    logic signed [33:0] sum;
    logic signed [31:0] sat;
    always_comb begin
        sum = (r_neg ? -$signed({6'd0, r_num}) : $signed({6'd0, r_num}))
              + 34'(r_off[ci]);
        if (sum > 34'sd2147483647)        sat = 32'h7fffffff;
        else if (sum < -34'sd2147483648)  sat = 32'h80000000;
        else                              sat = sum[31:0];
    end

    // reading / 100 truncated toward zero, by reciprocal multiply on the magnitude
    logic [31:0] rmag;
    logic [63:0] rprod;
    logic [31:0] qmag;
    logic signed [31:0] q;
    assign rmag  = r_reading[31] ? 32'(-r_reading) : 32'(r_reading);
    assign rprod = rmag * RECIP_100;
    assign qmag  = 32'(rprod >> RECIP_SHIFT);
    assign q     = r_reading[31] ? -$signed(qmag) : $signed(qmag);

    // finish: compare, flag update
    logic [4:0] f;
    logic rep;
    always_comb begin
        f = r_flg[ci];
        rep = 1'b0;
        if (r_q < r_lo[ci])       f[0] = 1'b1;
        else if (r_q > r_hi[ci])  f[2] = 1'b1;
        else begin
            f[0] = 1'b0; f[2] = 1'b0; f[4] = 1'b0;
        end
        if (!r_dom[ci] || r_up) f[4] = 1'b0;
        else if (f[0] || f[2])  f[4] = 1'b1;
        if (!f[4]) begin
            if (f[3]) begin
                if (!f[0]) begin
                    if (!f[2]) rep = 1'b1;
                    f[3] = 1'b0;
                end
            end else if (f[0]) begin
                f[3] = 1'b1; rep = 1'b1;
            end
            if (f[1]) begin
                if (!f[2]) begin
                    if (!f[0]) rep = 1'b1;
                    f[1] = 1'b0;
                end
            end else if (f[2]) begin
                f[1] = 1'b1; rep = 1'b1;
            end
        end
    end

    // aggregate supply state over switched rails
    logic any_bad, any_good;
    logic [1:0] sup;
    always_comb begin
        any_bad = 1'b0; any_good = 1'b0;
        for (int i = 0; i < CHANNELS; i++) begin
            if (r_dom[i]) begin
                if (r_flg[i][0] || r_flg[i][2]) any_bad = 1'b1;
                else any_good = 1'b1;
            end
        end
        if (!any_bad && any_good)      sup = SUP_ON;
        else if (!any_good && any_bad) sup = SUP_OFF;
        else                           sup = SUP_FAULT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dom <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_mul[i] <= '0; r_div[i] <= 15'd1; r_off[i] <= '0;
                r_lo[i] <= '0; r_hi[i] <= '0; r_flg[i] <= '0;
            end
        end else begin
            if (i_cmd.load) begin
                r_mul[li] <= i_item[33:18];
                r_div[li] <= i_item[48:34];
                r_off[li] <= i_item[80:49];
                r_lo[li]  <= i_item[112:81];
                r_hi[li]  <= i_item[144:113];
                r_dom[li] <= i_item[145];
            end
            if (i_cmd.finish) r_flg[ci] <= f;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ch  <= ich;
            r_raw <= i_item[16:5];
            r_up  <= i_item[17];
        end
        if (i_cmd.blank) begin
            r_reading <= '0; r_status <= ST_NORMAL; r_report <= 1'b0;
        end
        if (i_cmd.start_mul) begin
            r_neg <= prod[28];
            r_num <= pmag;
            r_rem <= '0;
            r_dv  <= (r_div[ci] == 15'd0) ? 15'd1 : r_div[ci];
            r_cnt <= '0;
        end
        if (i_cmd.step_div) begin
            if (!trial[15]) r_rem <= trial[14:0];
            else            r_rem <= {r_rem[13:0], r_num[27]};
            r_num <= {r_num[26:0], ~trial[15]};
            r_cnt <= r_cnt + 5'd1;
        end
        if (i_cmd.saturate) r_reading <= sat;
        if (i_cmd.quotient) r_q <= q;
        if (i_cmd.finish) begin
            r_report  <= rep;
            if (f[4])      r_status <= ST_IGNORED;
            else if (f[0]) r_status <= ST_UNDER;
            else if (f[2]) r_status <= ST_OVER;
            else           r_status <= ST_NORMAL;
        end
    end

    assign o_result = {7'd0, sup, r_report, r_status, r_reading, r_ch};
endmodule

/* rtl/core/rmla_checker.sv */
`timescale 1ns / 1ps
module rmla_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input open with result pending");
    a_sup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[40:39] != 2'd3)
        else $error("bad supply state");
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second item taken");
endmodule

bind rail_monitor_limit_alert rmla_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
module tb;
    import rmla_pkg::*;

    localparam int NCH = 16;

    // stream input item, fields from the lowest bit up
    typedef struct {
        logic              op;
        logic [3:0]        channel;
        logic [11:0]       raw_sample;
        logic              supply_up;
        logic signed [15:0] scale_mul;
        logic [14:0]       scale_div;
        logic signed [31:0] scale_offset;
        logic signed [31:0] limit_low;
        logic signed [31:0] limit_high;
        logic              switched_domain;
    } rail_item_t;

    typedef struct {
        logic [3:0]         out_channel;
        logic signed [31:0] scaled_reading;
        logic [1:0]         status;
        logic               report;
        logic [1:0]         supply_state;
    } rail_result_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [IN_W-1:0]      s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [OUT_W-1:0]     m_axis_tdata;

    rail_monitor_limit_alert uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // predictor copy of the channel table and flags
    logic signed [15:0] mul_tab [NCH];
    logic [14:0]        div_tab [NCH];
    logic signed [31:0] off_tab [NCH];
    logic signed [31:0] lo_tab [NCH];
    logic signed [31:0] hi_tab [NCH];
    logic               dom_tab [NCH];
    logic [4:0]         flags [NCH];

    localparam logic [4:0] FL_UNDER = 5'h01, FL_WARN_OVER = 5'h02, FL_OVER = 5'h04,
        FL_WARN_UNDER = 5'h08, FL_IGNORED = 5'h10;

    rail_item_t   pending_items [$];
    rail_result_t expected_results [$];
    int           fail_count = 0;
    int           idle_phase = 0;   // 0 sender light, 1 receiver light, 2 no idling

    function automatic logic [1:0] rail_supply_state();
        int bad, good;
        bad = 0;
        good = 0;
        for (int i = 0; i < NCH; i++)
            if (dom_tab[i]) begin
                if (flags[i] & (FL_UNDER | FL_OVER)) bad++;
                else good++;
            end
        if (bad == 0 && good > 0) return SUP_ON;
        if (good == 0 && bad > 0) return SUP_OFF;
        return SUP_FAULT;
    endfunction

    // applies one item to the table copy and returns the result it should give
    function automatic rail_result_t rail_predict(rail_item_t it);
        rail_result_t r;
        longint prod, d, rd, q;
        logic [4:0] f;
        int c;
        c = int'(it.channel);
        r.out_channel = it.channel;
        r.scaled_reading = 32'sd0;
        r.status = ST_NORMAL;
        r.report = 1'b0;
        if (it.op == OP_LOAD) begin
            mul_tab[c] = it.scale_mul;
            div_tab[c] = it.scale_div;
            off_tab[c] = it.scale_offset;
            lo_tab[c] = it.limit_low;
            hi_tab[c] = it.limit_high;
            dom_tab[c] = it.switched_domain;
        end else begin
            prod = longint'(it.raw_sample) * longint'(mul_tab[c]);
            d = (div_tab[c] == 0) ? 64'sd1 : longint'(div_tab[c]);
            rd = prod / d + longint'(off_tab[c]);
            if (rd > 64'sd2147483647) rd = 64'sd2147483647;
            if (rd < -64'sd2147483648) rd = -64'sd2147483648;
            q = rd / longint'(LIMIT_SCALE);
            f = flags[c];
            if (q < longint'(lo_tab[c])) f |= FL_UNDER;
            else if (q > longint'(hi_tab[c])) f |= FL_OVER;
            else f &= ~(FL_UNDER | FL_OVER | FL_IGNORED);
            if (!dom_tab[c] || it.supply_up) f &= ~FL_IGNORED;
            else if (f & (FL_UNDER | FL_OVER)) f |= FL_IGNORED;
            if (!(f & FL_IGNORED)) begin
                if (f & FL_WARN_UNDER) begin
                    if (!(f & FL_UNDER)) begin
                        if (!(f & FL_OVER)) r.report = 1'b1;
                        f &= ~FL_WARN_UNDER;
                    end
                end else if (f & FL_UNDER) begin
                    f |= FL_WARN_UNDER;
                    r.report = 1'b1;
                end
                if (f & FL_WARN_OVER) begin
                    if (!(f & FL_OVER)) begin
                        if (!(f & FL_UNDER)) r.report = 1'b1;
                        f &= ~FL_WARN_OVER;
                    end
                end else if (f & FL_OVER) begin
                    f |= FL_WARN_OVER;
                    r.report = 1'b1;
                end
            end
            flags[c] = f;
            r.scaled_reading = rd[31:0];
            if (f & FL_IGNORED) r.status = ST_IGNORED;
            else if (f & FL_UNDER) r.status = ST_UNDER;
            else if (f & FL_OVER) r.status = ST_OVER;
            else r.status = ST_NORMAL;
        end
        r.supply_state = rail_supply_state();
        return r;
    endfunction

    function automatic logic [IN_W-1:0] pack_item(rail_item_t it);
        logic [IN_W-1:0] v;
        v = IN_W'({it.switched_domain, it.limit_high, it.limit_low, it.scale_offset,
             it.scale_div, it.scale_mul, it.supply_up, it.raw_sample, it.channel, it.op});
        return v;
    endfunction

    function automatic rail_item_t make_sample(int ch, int raw, bit up);
        rail_item_t it;
        it = '{default: '0};
        it.op = OP_SAMPLE;
        it.channel = 4'(ch);
        it.raw_sample = 12'(raw);
        it.supply_up = up;
        // noise in the table fields that a sample ignores
        it.scale_mul = 16'($urandom);
        it.scale_div = 15'($urandom);
        it.scale_offset = $urandom;
        it.limit_low = $urandom;
        it.limit_high = $urandom;
        it.switched_domain = 1'($urandom);
        return it;
    endfunction

    function automatic rail_item_t make_load(int ch, int mul, int dv, int off, int lo, int hi,
                                             bit dom);
        rail_item_t it;
        it.op = OP_LOAD;
        it.channel = 4'(ch);
        it.raw_sample = 12'($urandom);
        it.supply_up = 1'($urandom);
        it.scale_mul = 16'(mul);
        it.scale_div = 15'(dv);
        it.scale_offset = off;
        it.limit_low = lo;
        it.limit_high = hi;
        it.switched_domain = dom;
        return it;
    endfunction

    // plausible rail setup, now and then fully random: readings around the window so limits trip both ways
    function automatic rail_item_t random_load();
        int mul, dv, lo, hi;
        mul = $urandom_range(1, 3000);
        if ($urandom_range(0, 4) == 0) mul = -mul;
        dv = $urandom_range(1, 4000);
        lo = $urandom_range(0, 400);
        hi = lo + $urandom_range(0, 400);
        if ($urandom_range(0, 9) == 0)
            return make_load($urandom_range(0, 15), $urandom, $urandom, $urandom, $urandom,
                             $urandom, 1'($urandom));
        return make_load($urandom_range(0, 15), mul, dv, $urandom_range(0, 20000),
                         lo, hi, 1'($urandom_range(0, 1)));
    endfunction

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #200ms;
        $display("FAIL rail_monitor_limit_alert");
        $finish;
    end

    // driver: takes items off the pending queue, idles at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) expected_results.push_back(rail_predict(pending_items.pop_front()));
            if (pending_items.size() > 0 &&
                !(idle_phase == 0 && $urandom_range(0, 99) < 13) &&
                !(idle_phase == 1 && $urandom_range(0, 99) < 84)) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= pack_item(pending_items[0]);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor: checks each accepted result against the oldest expectation
    always @(posedge i_clk) begin
        rail_result_t e;
        logic [3:0] a_ch;
        logic [31:0] a_rd;
        logic [1:0] a_st, a_sup;
        logic a_rep;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                {a_sup, a_rep, a_st, a_rd, a_ch} = m_axis_tdata[40:0];
                if (expected_results.size() == 0) begin
                    $error("result with none expected: %h", m_axis_tdata);
                    fail_count++;
                end else begin
                    e = expected_results.pop_front();
                    if (a_ch !== e.out_channel) begin
                        $error("out_channel exp %0d got %0d", e.out_channel, a_ch);
                        fail_count++;
                    end
                    if (a_rd !== e.scaled_reading) begin
                        $error("scaled_reading exp %0d got %0d", e.scaled_reading,
                               $signed(a_rd));
                        fail_count++;
                    end
                    if (a_st !== e.status) begin
                        $error("status exp %0d got %0d", e.status, a_st);
                        fail_count++;
                    end
                    if (a_rep !== e.report) begin
                        $error("report exp %0d got %0d", e.report, a_rep);
                        fail_count++;
                    end
                    if (a_sup !== e.supply_state) begin
                        $error("supply_state exp %0d got %0d", e.supply_state, a_sup);
                        fail_count++;
                    end
                end
            end
            m_axis_tready <= !(idle_phase == 0 && $urandom_range(0, 99) < 84) &&
                             !(idle_phase == 1 && $urandom_range(0, 99) < 13);
        end
    end

    initial begin
        int n, ch, wait_cycles;
        for (int i = 0; i < NCH; i++) begin
            mul_tab[i] = 0; div_tab[i] = 1; off_tab[i] = 0;
            lo_tab[i] = 0; hi_tab[i] = 0; dom_tab[i] = 0; flags[i] = 0;
        end
        i_rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        m_axis_tready = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: reset table, extremes, zero divisor, saturation, jumps, ignored rail
        pending_items.push_back(make_sample(0, 4095, 0));
        pending_items.push_back(make_load(1, 32767, 1, 32'sh7fffffff, 0, 100, 0));
        pending_items.push_back(make_sample(1, 4095, 1));          // saturate high
        pending_items.push_back(make_load(2, -32768, 1, 32'sh80000000, -5, 5, 0));
        pending_items.push_back(make_sample(2, 4095, 0));          // saturate low
        pending_items.push_back(make_load(3, 1000, 0, 0, 100, 200, 1)); // zero divisor
        pending_items.push_back(make_sample(3, 15, 1));            // 150: normal
        pending_items.push_back(make_sample(3, 5, 1));             // under, report
        pending_items.push_back(make_sample(3, 30, 1));            // jump to over
        pending_items.push_back(make_sample(3, 15, 1));            // back to normal
        pending_items.push_back(make_sample(3, 0, 0));             // under, ignored
        pending_items.push_back(make_sample(3, 0, 1));             // under once up
        pending_items.push_back(make_sample(3, 4095, 0));          // over, ignored
        pending_items.push_back(make_sample(3, 15, 0));            // normal clears
        pending_items.push_back(make_load(4, 7, 32767, -12345, -100, -50, 1));
        pending_items.push_back(make_sample(4, 2048, 1));
        pending_items.push_back(make_sample(15, 1, 1));
        pending_items.push_back(make_load(15, -1, 3, 0, 32'sh80000000, 32'sh7fffffff, 1));
        pending_items.push_back(make_sample(15, 4095, 0));
        pending_items.push_back(make_load(3, 1000, 10, 0, 0, 0, 0));
        pending_items.push_back(make_sample(3, 0, 0));

        // random: mostly samples on random rails, with reloads in between
        for (int phase = 0; phase < 3; phase++) begin
            n = (phase == 0) ? 300 : (phase == 1 ? 300 : 1000);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 9) == 0) pending_items.push_back(random_load());
                else begin
                    ch = $urandom_range(0, 15);
                    pending_items.push_back(make_sample(ch,
                        ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) * 4095)
                                                     : $urandom_range(0, 4095),
                        $urandom_range(0, 3) != 0));
                end
            end
            while (pending_items.size() > 0 || s_axis_tvalid) @(posedge i_clk);
            while (expected_results.size() > 0) @(posedge i_clk);
            idle_phase = phase + 1;
        end

        wait_cycles = 0;
        while (expected_results.size() > 0 && wait_cycles < 100000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (100) @(posedge i_clk);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("PASS rail_monitor_limit_alert");
        else
            $display("FAIL rail_monitor_limit_alert");
        $finish;
    end
endmodule
